### rtl/core/nbhd_pkg.sv
// Shared types, codes and constant tables for the nested block header deframer.
// No dependencies; nbhd_step and the deframer top in rtl/core use this package.
package nbhd_pkg;

    localparam int SIZE_BITS_DEF = 16;

    // Parser phase
    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_ID,
        PH_TERM,
        PH_PAYLOAD
    } phase_t;

    // Header layout selected by the prefix byte
    typedef enum logic [1:0] {
        HV_PLAIN,
        HV_WIDE,
        HV_SHORT5,
        HV_LONG6
    } hdr_var_t;

    // Byte roles
    localparam logic [2:0] ROLE_PREFIX  = 3'd0;
    localparam logic [2:0] ROLE_HEADER  = 3'd1;
    localparam logic [2:0] ROLE_ID      = 3'd2;
    localparam logic [2:0] ROLE_TERM    = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd4;

    // Container kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_NODES = 2'd1;
    localparam logic [1:0] KIND_LINKS = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_TRUNC   = 2'd2;

    // Prefix bytes
    localparam logic [7:0] PFX_WIDE_A = 8'h81;
    localparam logic [7:0] PFX_WIDE_B = 8'h82;
    localparam logic [7:0] PFX_SHORT5 = 8'h61;
    localparam logic [7:0] PFX_LONG6  = 8'hA1;

    localparam int ID_NAME_LEN = 8;

    // "NAVNODES" and "NAVLINKS"
    localparam logic [7:0] NODES_NAME [ID_NAME_LEN] =
        '{8'h4E, 8'h41, 8'h56, 8'h4E, 8'h4F, 8'h44, 8'h45, 8'h53};
    localparam logic [7:0] LINKS_NAME [ID_NAME_LEN] =
        '{8'h4E, 8'h41, 8'h56, 8'h4C, 8'h49, 8'h4E, 8'h4B, 8'h53};

    // Parser state other than the size counters
    typedef struct packed {
        phase_t     phase;
        hdr_var_t   variant;
        logic [2:0] header_count;
        logic [7:0] size_low;
        logic [7:0] id_len;
        logic [7:0] id_count;
        logic [1:0] id_match;    // bit 0 nodes still possible, bit 1 links
        logic       level;
        logic [1:0] outer_kind;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:        PH_START,
        variant:      HV_PLAIN,
        header_count: 3'd0,
        size_low:     8'd0,
        id_len:       8'd0,
        id_count:     8'd0,
        id_match:     2'b11,
        level:        1'b0,
        outer_kind:   KIND_PLAIN
    };

    // One labeled word
    typedef struct packed {
        logic [2:0]  byte_role;
        logic        nest_level;
        logic [2:0]  header_index;
        logic [7:0]  id_length;
        logic [15:0] block_size;
        logic [1:0]  container_kind;
        logic        block_end;
        logic [1:0]  error_code;
    } result_t;

    // Index of the last header byte (it carries the id length)
    function automatic logic [2:0] hdr_last_idx(input hdr_var_t v);
        logic [2:0] idx;
        unique case (v)
            HV_PLAIN:  idx = 3'd3;
            HV_WIDE:   idx = 3'd3;
            HV_SHORT5: idx = 3'd4;
            HV_LONG6:  idx = 3'd5;
            default:   idx = 3'd3;
        endcase
        return idx;
    endfunction

endpackage

### rtl/core/nbhd_if.sv
// Valid/ready stream interfaces for the deframer's input and result channels.
// Depends on nothing.
interface nbhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface nbhd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic        nest_level;
    logic [2:0]  header_index;
    logic [7:0]  id_length;
    logic [15:0] block_size;
    logic [1:0]  container_kind;
    logic        block_end;
    logic [1:0]  error_code;

    modport source (output valid, output byte_role, output nest_level, output header_index,
                    output id_length, output block_size, output container_kind,
                    output block_end, output error_code, input ready);
    modport sink   (input valid, input byte_role, input nest_level, input header_index,
                    input id_length, input block_size, input container_kind,
                    input block_end, input error_code, output ready);
endinterface

### rtl/core/nbhd_step.sv
// Combinational parse step: labels one word and computes the next parser state.
// Depends on nbhd_pkg.
module nbhd_step #(
    parameter int SIZE_BITS = nbhd_pkg::SIZE_BITS_DEF
) (
    input  nbhd_pkg::state_t      st,
    input  logic [SIZE_BITS-1:0]  cur_size,
    input  logic [SIZE_BITS-1:0]  outer_rem,
    input  logic [SIZE_BITS-1:0]  inner_rem,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output nbhd_pkg::state_t      st_next,
    output logic [SIZE_BITS-1:0]  cur_size_next,
    output logic [SIZE_BITS-1:0]  outer_rem_next,
    output logic [SIZE_BITS-1:0]  inner_rem_next,
    output nbhd_pkg::result_t     res
);

    localparam logic [31:0] SIZE_MAX = 32'((64'd1 << SIZE_BITS) - 64'd1);

    function automatic logic [SIZE_BITS-1:0] clamp(input logic [15:0] raw);
        logic [SIZE_BITS-1:0] r;
        if (32'(raw) > SIZE_MAX)
        begin
            r = SIZE_BITS'(SIZE_MAX);
        end
        else
        begin
            r = SIZE_BITS'(raw);
        end
        return r;
    endfunction

    logic       is_prefix;
    logic [2:0] role;
    logic [2:0] hidx;
    logic [15:0] size_wide;

    assign is_prefix = (in_byte == nbhd_pkg::PFX_WIDE_A) || (in_byte == nbhd_pkg::PFX_WIDE_B) ||
                       (in_byte == nbhd_pkg::PFX_SHORT5) || (in_byte == nbhd_pkg::PFX_LONG6);

    // Output decode: role and header position from the current phase
    always_comb
    begin
        role = nbhd_pkg::ROLE_PAYLOAD;
        hidx = 3'd0;
        unique case (st.phase)
            nbhd_pkg::PH_START:
            begin
                role = is_prefix ? nbhd_pkg::ROLE_PREFIX : nbhd_pkg::ROLE_HEADER;
            end
            nbhd_pkg::PH_HEADER:
            begin
                role = nbhd_pkg::ROLE_HEADER;
                hidx = st.header_count;
            end
            nbhd_pkg::PH_ID:      role = nbhd_pkg::ROLE_ID;
            nbhd_pkg::PH_TERM:    role = nbhd_pkg::ROLE_TERM;
            nbhd_pkg::PH_PAYLOAD: role = nbhd_pkg::ROLE_PAYLOAD;
            default:              role = nbhd_pkg::ROLE_PAYLOAD;
        endcase
    end

    // Next state, size counters and the remaining result fields
    always_comb
    begin
        logic       lvl;
        logic       done;
        logic       endf;
        logic [1:0] kind;
        logic [1:0] err;
        logic [1:0] k;
        logic [7:0] id_cnt_inc;

        lvl        = st.level;
        done       = 1'b0;
        endf       = 1'b0;
        kind       = nbhd_pkg::KIND_PLAIN;
        err        = nbhd_pkg::ERR_NONE;
        k          = nbhd_pkg::KIND_PLAIN;
        id_cnt_inc = st.id_count + 8'd1;

        st_next        = st;
        cur_size_next  = cur_size;
        outer_rem_next = outer_rem;
        inner_rem_next = inner_rem;

        unique case (st.phase)
            nbhd_pkg::PH_START:
            begin
                cur_size_next    = '0;
                st_next.id_len   = 8'd0;
                st_next.size_low = 8'd0;
                if (!lvl)
                begin
                    st_next.outer_kind = nbhd_pkg::KIND_PLAIN;
                end
                if (is_prefix)
                begin
                    if (in_byte == nbhd_pkg::PFX_SHORT5)
                    begin
                        st_next.variant = nbhd_pkg::HV_SHORT5;
                    end
                    else if (in_byte == nbhd_pkg::PFX_LONG6)
                    begin
                        st_next.variant = nbhd_pkg::HV_LONG6;
                    end
                    else
                    begin
                        st_next.variant = nbhd_pkg::HV_WIDE;
                    end
                    st_next.header_count = 3'd0;
                end
                else
                begin
                    st_next.variant      = nbhd_pkg::HV_PLAIN;
                    st_next.header_count = 3'd1;
                end
                st_next.phase = nbhd_pkg::PH_HEADER;
            end
            nbhd_pkg::PH_HEADER:
            begin
                if ((st.variant == nbhd_pkg::HV_PLAIN && st.header_count == 3'd2) ||
                    (st.variant == nbhd_pkg::HV_SHORT5 && st.header_count == 3'd1))
                begin
                    cur_size_next = clamp({8'd0, in_byte});
                end
                if ((st.variant == nbhd_pkg::HV_WIDE || st.variant == nbhd_pkg::HV_LONG6) &&
                    st.header_count == 3'd1)
                begin
                    st_next.size_low = in_byte;
                end
                if ((st.variant == nbhd_pkg::HV_WIDE || st.variant == nbhd_pkg::HV_LONG6) &&
                    st.header_count == 3'd2)
                begin
                    cur_size_next = clamp({in_byte, st.size_low});
                end
                if (st.header_count >= nbhd_pkg::hdr_last_idx(st.variant))
                begin
                    st_next.id_len   = in_byte;
                    st_next.id_count = 8'd0;
                    st_next.id_match = 2'b11;
                    st_next.phase    = (in_byte != 8'd0) ? nbhd_pkg::PH_ID : nbhd_pkg::PH_TERM;
                end
                else
                begin
                    st_next.header_count = st.header_count + 3'd1;
                end
            end
            nbhd_pkg::PH_ID:
            begin
                if (st.id_count < 8'(nbhd_pkg::ID_NAME_LEN))
                begin
                    if (in_byte != nbhd_pkg::NODES_NAME[st.id_count[2:0]])
                    begin
                        st_next.id_match[0] = 1'b0;
                    end
                    if (in_byte != nbhd_pkg::LINKS_NAME[st.id_count[2:0]])
                    begin
                        st_next.id_match[1] = 1'b0;
                    end
                end
                else
                begin
                    st_next.id_match = 2'b00;
                end
                st_next.id_count = id_cnt_inc;
                if (id_cnt_inc >= st.id_len)
                begin
                    st_next.phase = nbhd_pkg::PH_TERM;
                end
            end
            nbhd_pkg::PH_TERM:
            begin
                if (!lvl)
                begin
                    if (st.id_len == 8'(nbhd_pkg::ID_NAME_LEN))
                    begin
                        if (st.id_match[0])
                        begin
                            k = nbhd_pkg::KIND_NODES;
                        end
                        else if (st.id_match[1])
                        begin
                            k = nbhd_pkg::KIND_LINKS;
                        end
                    end
                    st_next.outer_kind = k;
                end
                if (cur_size == '0)
                begin
                    done = 1'b1;
                end
                else if (!lvl && st_next.outer_kind != nbhd_pkg::KIND_PLAIN)
                begin
                    outer_rem_next = cur_size;
                    st_next.level  = 1'b1;
                    st_next.phase  = nbhd_pkg::PH_START;
                end
                else
                begin
                    if (!lvl)
                    begin
                        outer_rem_next = cur_size;
                    end
                    else
                    begin
                        inner_rem_next = cur_size;
                    end
                    st_next.phase = nbhd_pkg::PH_PAYLOAD;
                end
            end
            nbhd_pkg::PH_PAYLOAD:
            begin
                if (!lvl)
                begin
                    if (outer_rem != '0)
                    begin
                        outer_rem_next = outer_rem - SIZE_BITS'(1);
                    end
                    done = (outer_rem_next == '0);
                end
                else
                begin
                    if (inner_rem != '0)
                    begin
                        inner_rem_next = inner_rem - SIZE_BITS'(1);
                    end
                    done = (inner_rem_next == '0);
                end
            end
            default:
            begin
                st_next.phase = nbhd_pkg::PH_START;
            end
        endcase

        // Level bookkeeping: inner words also count down the container
        if (!lvl)
        begin
            kind = (role == nbhd_pkg::ROLE_TERM || role == nbhd_pkg::ROLE_PAYLOAD)
                   ? st_next.outer_kind : nbhd_pkg::KIND_PLAIN;
            if (done)
            begin
                endf          = 1'b1;
                st_next.phase = nbhd_pkg::PH_START;
            end
        end
        else
        begin
            kind = st.outer_kind;
            if (outer_rem_next != '0)
            begin
                outer_rem_next = outer_rem_next - SIZE_BITS'(1);
            end
            if (done)
            begin
                endf          = 1'b1;
                st_next.phase = nbhd_pkg::PH_START;
                if (outer_rem_next == '0)
                begin
                    st_next.level = 1'b0;
                end
            end
            else if (outer_rem_next == '0)
            begin
                endf          = 1'b1;
                err           = nbhd_pkg::ERR_OVERRUN;
                st_next.phase = nbhd_pkg::PH_START;
                st_next.level = 1'b0;
            end
        end

        res.byte_role      = role;
        res.nest_level     = lvl;
        res.header_index   = hidx;
        res.id_length      = st_next.id_len;
        res.block_size     = size_wide;
        res.container_kind = kind;
        res.block_end      = endf;

        // End of data set: flag a cut-off block, then restart clean
        if (in_last)
        begin
            if (err == nbhd_pkg::ERR_NONE &&
                !(st_next.phase == nbhd_pkg::PH_START && st_next.level == 1'b0))
            begin
                err = nbhd_pkg::ERR_TRUNC;
            end
        end
        res.error_code = err;

        if (in_last)
        begin
            st_next        = nbhd_pkg::STATE_RESET;
            cur_size_next  = '0;
            outer_rem_next = '0;
            inner_rem_next = '0;
        end
    end

    // Size as reported, before any end-of-data clear
    always_comb
    begin
        size_wide = 16'(cur_size);
        if (st.phase == nbhd_pkg::PH_START)
        begin
            size_wide = 16'd0;
        end
        else if (st.phase == nbhd_pkg::PH_HEADER)
        begin
            if ((st.variant == nbhd_pkg::HV_PLAIN && st.header_count == 3'd2) ||
                (st.variant == nbhd_pkg::HV_SHORT5 && st.header_count == 3'd1))
            begin
                size_wide = 16'(clamp({8'd0, in_byte}));
            end
            else if ((st.variant == nbhd_pkg::HV_WIDE || st.variant == nbhd_pkg::HV_LONG6) &&
                     st.header_count == 3'd2)
            begin
                size_wide = 16'(clamp({in_byte, st.size_low}));
            end
        end
    end

endmodule

### rtl/core/nested_block_header_deframer.sv
// Top level of the nested block header deframer: state and result registers.
// Depends on nbhd_pkg, nbhd_in_if / nbhd_out_if and nbhd_step.
//
//  channel  dir  handshake        word contents
//  in_ch    in   valid / ready    in_byte, in_last
//  out_ch   out  valid / ready    byte_role, nest_level, header_index, id_length,
//                                 block_size, container_kind, block_end, error_code
//
// One word in, one labeled word out. A word is accepted every cycle while
// in_ch.ready is high, and its label appears in the result register on the next
// cycle; the single parse step (header decode, id compare, size countdown) sits
// between the state registers and that register. in_ch.ready drops only while
// the result register is full and out_ch.ready is low. Reset puts the parser at
// top level, expecting a prefix or header byte. A word with in_last set also
// returns the parser to that state.
module nested_block_header_deframer #(
    parameter int SIZE_BITS = nbhd_pkg::SIZE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nbhd_in_if.sink    in_ch,
    nbhd_out_if.source out_ch
);

    nbhd_pkg::state_t     st_reg;
    nbhd_pkg::state_t     st_next;
    logic [SIZE_BITS-1:0] cur_size_reg;
    logic [SIZE_BITS-1:0] cur_size_next;
    logic [SIZE_BITS-1:0] outer_rem_reg;
    logic [SIZE_BITS-1:0] outer_rem_next;
    logic [SIZE_BITS-1:0] inner_rem_reg;
    logic [SIZE_BITS-1:0] inner_rem_next;
    nbhd_pkg::result_t    res_next;
    nbhd_pkg::result_t    res_reg;
    logic                 out_valid_reg;
    logic                 accept;

    // Result register frees up in the same cycle it is drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    nbhd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .st             (st_reg),
        .cur_size       (cur_size_reg),
        .outer_rem      (outer_rem_reg),
        .inner_rem      (inner_rem_reg),
        .in_byte        (in_ch.in_byte),
        .in_last        (in_ch.in_last),
        .st_next        (st_next),
        .cur_size_next  (cur_size_next),
        .outer_rem_next (outer_rem_next),
        .inner_rem_next (inner_rem_next),
        .res            (res_next)
    );

    // Parser state advances only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= nbhd_pkg::STATE_RESET;
            cur_size_reg  <= '0;
            outer_rem_reg <= '0;
            inner_rem_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg        <= st_next;
                cur_size_reg  <= cur_size_next;
                outer_rem_reg <= outer_rem_next;
                inner_rem_reg <= inner_rem_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.byte_role      = res_reg.byte_role;
    assign out_ch.nest_level     = res_reg.nest_level;
    assign out_ch.header_index   = res_reg.header_index;
    assign out_ch.id_length      = res_reg.id_length;
    assign out_ch.block_size     = res_reg.block_size;
    assign out_ch.container_kind = res_reg.container_kind;
    assign out_ch.block_end      = res_reg.block_end;
    assign out_ch.error_code     = res_reg.error_code;

`ifndef SYNTHESIS
    // Inner level only exists inside a recognized container
    a_level_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.level |-> st_reg.outer_kind != nbhd_pkg::KIND_PLAIN)
        else $error("inner level active without container kind");

    // An overrun always closes the block
    a_overrun_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.error_code == nbhd_pkg::ERR_OVERRUN |-> out_ch.block_end)
        else $error("overrun reported without block end");

    // Nonzero header position only on header bytes
    a_hidx_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.header_index != 3'd0 |->
        out_ch.byte_role == nbhd_pkg::ROLE_HEADER)
        else $error("header index on non-header byte");

    // A word with in_last leaves the parser at top level, between blocks
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.in_last |=>
        st_reg.phase == nbhd_pkg::PH_START && !st_reg.level)
        else $error("parser not restarted after last word");
`endif

endmodule

### verif/nbhd_label_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the nested block header deframer: mirrors the parser on every accepted byte
// and compares each label word, in order. Depends on nbhd_pkg and nbhd_in_if / nbhd_out_if.
module nbhd_label_checker
    import nbhd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    nbhd_in_if   in_mon,
    nbhd_out_if  out_mon,
    output int   fail_count,
    output int   pending,
    output int   words_checked,
    output int   inner_words,
    output int   overruns,
    output int   truncations
);

    // Mirror of the parser state
    phase_t      ph;
    hdr_var_t    form;
    logic [2:0]  hdr_pos;
    logic [7:0]  size_lo;
    logic [7:0]  id_len;
    logic [7:0]  id_pos;
    logic [1:0]  name_hits;     // bit 0 nodes name still possible, bit 1 links
    logic [15:0] outer_left;
    logic [15:0] inner_left;
    logic        nested;
    logic [1:0]  cont_kind;
    logic [15:0] blk_size;

    result_t label_q[$];

    int n_fail    = 0;
    int n_pending = 0;
    int n_words   = 0;
    int n_inner   = 0;
    int n_overrun = 0;
    int n_trunc   = 0;

    assign fail_count    = n_fail;
    assign pending       = n_pending;
    assign words_checked = n_words;
    assign inner_words   = n_inner;
    assign overruns      = n_overrun;
    assign truncations   = n_trunc;

    function automatic void clear_parser();
        ph         = PH_START;
        form       = HV_PLAIN;
        hdr_pos    = '0;
        size_lo    = '0;
        id_len     = '0;
        id_pos     = '0;
        name_hits  = 2'b11;
        outer_left = '0;
        inner_left = '0;
        nested     = 1'b0;
        cont_kind  = KIND_PLAIN;
        blk_size   = '0;
    endfunction

    // Label one byte and advance the mirror.
    function automatic result_t label_byte(input logic [7:0] b, input logic is_last);
        result_t    r;
        logic       lvl;
        logic       done;
        logic [2:0] pos;
        logic [2:0] hdr_end;
        lvl  = nested;
        done = 1'b0;
        r    = '0;
        case (ph)
            PH_START:
            begin
                blk_size = '0;
                id_len   = '0;
                size_lo  = '0;
                if (!lvl)
                    cont_kind = KIND_PLAIN;
                if (b == PFX_WIDE_A || b == PFX_WIDE_B || b == PFX_SHORT5 || b == PFX_LONG6)
                begin
                    r.byte_role = ROLE_PREFIX;
                    form = (b == PFX_SHORT5) ? HV_SHORT5 : (b == PFX_LONG6) ? HV_LONG6 : HV_WIDE;
                    hdr_pos = 3'd0;
                end
                else
                begin
                    r.byte_role = ROLE_HEADER;
                    form        = HV_PLAIN;
                    hdr_pos     = 3'd1;
                end
                ph = PH_HEADER;
            end
            PH_HEADER:
            begin
                pos            = hdr_pos;
                r.byte_role    = ROLE_HEADER;
                r.header_index = pos;
                case (form)
                    HV_PLAIN:
                        if (pos == 3'd2)
                            blk_size = {8'h00, b};
                    HV_SHORT5:
                        if (pos == 3'd1)
                            blk_size = {8'h00, b};
                    default:
                    begin
                        if (pos == 3'd1)
                            size_lo = b;
                        if (pos == 3'd2)
                            blk_size = {b, size_lo};
                    end
                endcase
                hdr_end = (form == HV_SHORT5) ? 3'd4 : (form == HV_LONG6) ? 3'd5 : 3'd3;
                if (pos >= hdr_end)
                begin
                    id_len    = b;
                    id_pos    = '0;
                    name_hits = 2'b11;
                    ph        = (b != 8'd0) ? PH_ID : PH_TERM;
                end
                else
                    hdr_pos = pos + 3'd1;
            end
            PH_ID:
            begin
                r.byte_role = ROLE_ID;
                if (id_pos < 8'(ID_NAME_LEN))
                begin
                    if (b != NODES_NAME[id_pos[2:0]])
                        name_hits[0] = 1'b0;
                    if (b != LINKS_NAME[id_pos[2:0]])
                        name_hits[1] = 1'b0;
                end
                else
                    name_hits = 2'b00;
                id_pos = id_pos + 8'd1;
                if (id_pos >= id_len)
                    ph = PH_TERM;
            end
            PH_TERM:
            begin
                r.byte_role = ROLE_TERM;
                if (!lvl)
                begin
                    if (id_len == 8'(ID_NAME_LEN) && name_hits[0])
                        cont_kind = KIND_NODES;
                    else if (id_len == 8'(ID_NAME_LEN) && name_hits[1])
                        cont_kind = KIND_LINKS;
                    else
                        cont_kind = KIND_PLAIN;
                end
                if (blk_size == '0)
                    done = 1'b1;
                else if (!lvl && cont_kind != KIND_PLAIN)
                begin
                    outer_left = blk_size;
                    nested     = 1'b1;
                    ph         = PH_START;
                end
                else
                begin
                    if (!lvl)
                        outer_left = blk_size;
                    else
                        inner_left = blk_size;
                    ph = PH_PAYLOAD;
                end
            end
            default:
            begin
                r.byte_role = ROLE_PAYLOAD;
                if (!lvl)
                begin
                    if (outer_left != '0)
                        outer_left = outer_left - 16'd1;
                    if (outer_left == '0)
                        done = 1'b1;
                end
                else
                begin
                    if (inner_left != '0)
                        inner_left = inner_left - 16'd1;
                    if (inner_left == '0)
                        done = 1'b1;
                end
            end
        endcase

        if (!lvl)
        begin
            r.container_kind = (r.byte_role >= ROLE_TERM) ? cont_kind : KIND_PLAIN;
            if (done)
            begin
                r.block_end = 1'b1;
                ph          = PH_START;
            end
        end
        else
        begin
            // every inner byte also uses up one byte of the container
            r.container_kind = cont_kind;
            if (outer_left != '0)
                outer_left = outer_left - 16'd1;
            if (done)
            begin
                r.block_end = 1'b1;
                ph          = PH_START;
                if (outer_left == '0)
                    nested = 1'b0;
            end
            else if (outer_left == '0)
            begin
                r.block_end  = 1'b1;
                r.error_code = ERR_OVERRUN;
                ph           = PH_START;
                nested       = 1'b0;
            end
        end

        r.nest_level = lvl;
        r.id_length  = id_len;
        r.block_size = blk_size;

        if (is_last)
        begin
            if (r.error_code == ERR_NONE && !(ph == PH_START && !nested))
                r.error_code = ERR_TRUNC;
            clear_parser();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    initial clear_parser();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_parser();
            label_q.delete();
            n_pending <= 0;
        end
        else
        begin
            // result first: it belongs to a byte taken on an earlier edge
            if (out_mon.valid && out_mon.ready)
            begin
                n_words++;
                if (out_mon.nest_level === 1'b1)
                    n_inner++;
                if (out_mon.error_code === ERR_OVERRUN)
                    n_overrun++;
                if (out_mon.error_code === ERR_TRUNC)
                    n_trunc++;
                if (label_q.size() == 0)
                begin
                    $error("label word arrived with no byte outstanding");
                    n_fail++;
                end
                else
                begin
                    want = label_q.pop_front();
                    check_field("byte_role", 16'(want.byte_role), 16'(out_mon.byte_role));
                    check_field("nest_level", 16'(want.nest_level), 16'(out_mon.nest_level));
                    check_field("header_index", 16'(want.header_index),
                                16'(out_mon.header_index));
                    check_field("id_length", 16'(want.id_length), 16'(out_mon.id_length));
                    check_field("block_size", want.block_size, out_mon.block_size);
                    check_field("container_kind", 16'(want.container_kind),
                                16'(out_mon.container_kind));
                    check_field("block_end", 16'(want.block_end), 16'(out_mon.block_end));
                    check_field("error_code", 16'(want.error_code), 16'(out_mon.error_code));
                end
            end
            if (in_mon.valid && in_mon.ready)
                label_q.push_back(label_byte(in_mon.in_byte, in_mon.in_last));
            n_pending <= label_q.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte stimulus and the verdict.
// Depends on nbhd_pkg, the channel interfaces, the deframer and nbhd_label_checker.
module testbench;
    import nbhd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BYTES   = 450;
    // Longest quiet stretch of a correct run comes from random idling or
    // stalling; this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    // The label is registered in the cycle after its byte is accepted; spare cycles catch strays.
    localparam int DRAIN_CYCLES   = 16;

    // Styles of block id
    localparam int ID_RANDOM = 0;
    localparam int ID_NODES  = 1;
    localparam int ID_LINKS  = 2;
    localparam int ID_NEAR   = 3;

    // Pacing of the two channels
    typedef enum int {
        PACE_FULL,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } pace_t;

    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    nbhd_in_if  byte_ch ();
    nbhd_out_if label_ch ();

    nested_block_header_deframer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (label_ch)
    );

    int fail_count;
    int pending;
    int words_checked;
    int inner_words;
    int overruns;
    int truncations;

    nbhd_label_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (byte_ch),
        .out_mon       (label_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .inner_words   (inner_words),
        .overruns      (overruns),
        .truncations   (truncations)
    );

    // Percent chance per cycle of a sender gap / receiver stall
    int idle_pct  = 0;
    int stall_pct = 0;

    // Byte images of the data set being built. Container payloads are built
    // in inner_q first so that their length is known before the header.
    logic [7:0] frame_q[$];
    logic [7:0] inner_q[$];
    logic [7:0] id_buf[$];
    bit         to_inner = 1'b0;

    int bytes_sent   = 0;
    int random_bytes = 0;
    int sets_sent    = 0;

    // Receiver side: ready redrawn on each falling edge.
    always @(negedge clk)
        label_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic void set_pace(input pace_t p);
        case (p)
            PACE_SRC_IDLE:
            begin
                idle_pct  = 63;
                stall_pct = 0;
            end
            PACE_SNK_STALL:
            begin
                idle_pct  = 0;
                stall_pct = 63;
            end
            PACE_BOTH:
            begin
                idle_pct  = 12;
                stall_pct = 12;
            end
            default:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    endfunction

    function automatic void put(input logic [7:0] b);
        if (to_inner)
            inner_q.push_back(b);
        else
            frame_q.push_back(b);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // First byte of a prefix-less header: anything but a prefix code.
    function automatic logic [7:0] plain_lead();
        logic [7:0] b;
        do
            b = rand_byte();
        while (b == PFX_WIDE_A || b == PFX_WIDE_B || b == PFX_SHORT5 || b == PFX_LONG6);
        return b;
    endfunction

    // Sizes above one byte need a layout with a 16-bit size field.
    function automatic hdr_var_t pick_form(input logic [15:0] size);
        if (size > 16'd255)
            return $urandom_range(0, 1) ? HV_WIDE : HV_LONG6;
        return hdr_var_t'($urandom_range(0, 3));
    endfunction

    function automatic void put_header(input hdr_var_t f, input logic [15:0] size,
                                       input logic [7:0] idlen);
        case (f)
            HV_PLAIN:
            begin
                put(plain_lead());
                put(rand_byte());
                put(size[7:0]);
                put(idlen);
            end
            HV_WIDE:
            begin
                put($urandom_range(0, 1) ? PFX_WIDE_A : PFX_WIDE_B);
                put(rand_byte());
                put(size[7:0]);
                put(size[15:8]);
                put(idlen);
            end
            HV_SHORT5:
            begin
                put(PFX_SHORT5);
                put(rand_byte());
                put(size[7:0]);
                put(rand_byte());
                put(rand_byte());
                put(idlen);
            end
            default:
            begin
                put(PFX_LONG6);
                put(rand_byte());
                put(size[7:0]);
                put(size[15:8]);
                put(rand_byte());
                put(rand_byte());
                put(idlen);
            end
        endcase
    endfunction

    // Fill id_buf. Near misses are a container name with one bit flipped,
    // one character added, or the last one dropped.
    function automatic void make_id(input int style, input bit allow_long);
        int  n;
        int  k;
        bit  links;
        id_buf.delete();
        case (style)
            ID_NODES:
                for (k = 0; k < ID_NAME_LEN; k++)
                    id_buf.push_back(NODES_NAME[k]);
            ID_LINKS:
                for (k = 0; k < ID_NAME_LEN; k++)
                    id_buf.push_back(LINKS_NAME[k]);
            ID_NEAR:
            begin
                links = 1'($urandom_range(0, 1));
                for (k = 0; k < ID_NAME_LEN; k++)
                    id_buf.push_back(links ? LINKS_NAME[k] : NODES_NAME[k]);
                case ($urandom_range(0, 2))
                    0:       id_buf[$urandom_range(0, ID_NAME_LEN - 1)] ^=
                                 8'(1 << $urandom_range(0, 7));
                    1:       id_buf.push_back(rand_byte());
                    default: void'(id_buf.pop_back());
                endcase
            end
            default:
            begin
                if (allow_long && $urandom_range(0, 59) == 0)
                    n = $urandom_range(100, 255);
                else
                    n = $urandom_range(0, 10);
                for (k = 0; k < n; k++)
                    id_buf.push_back(rand_byte());
            end
        endcase
    endfunction

    function automatic void put_id();
        foreach (id_buf[k])
            put(id_buf[k]);
        put(8'h00);
    endfunction

    // A block whose payload is skipped. Inside a container it stays small
    // and may even carry a container name, which must not match there.
    function automatic void plain_block(input bit inner);
        logic [15:0] size;
        int          r;
        int          k;
        r = $urandom_range(0, 99);
        if (inner)
            make_id((r < 70) ? ID_RANDOM : (r < 85) ? ID_NEAR : (r < 93) ? ID_NODES : ID_LINKS,
                    1'b0);
        else
            make_id((r < 75) ? ID_RANDOM : ID_NEAR, 1'b1);
        r = $urandom_range(0, 99);
        if (inner)
            size = 16'($urandom_range(0, 6));
        else if (r < 70)
            size = 16'($urandom_range(0, 8));
        else if (r < 95)
            size = 16'($urandom_range(9, 40));
        else
            size = 16'($urandom_range(256, 300));
        put_header(pick_form(size), size, 8'(id_buf.size()));
        put_id();
        for (k = 0; k < int'(size); k++)
            put(rand_byte());
    endfunction

    // A node or link container holding up to three inner blocks. With
    // overrun set, the declared size stops short of the end of the inner blocks.
    function automatic void container_block(input bit overrun);
        int          n_inner;
        logic [15:0] size;
        to_inner = 1'b1;
        inner_q.delete();
        n_inner = overrun ? $urandom_range(1, 3) : $urandom_range(0, 3);
        repeat (n_inner)
            plain_block(1'b1);
        to_inner = 1'b0;
        size = 16'(inner_q.size());
        if (overrun)
            size = 16'($urandom_range(1, inner_q.size() - 1));
        make_id($urandom_range(0, 1) ? ID_NODES : ID_LINKS, 1'b0);
        put_header(pick_form(size), size, 8'(id_buf.size()));
        put_id();
        foreach (inner_q[k])
            put(inner_q[k]);
    endfunction

    // Sender side: random gaps, then hold the word until it is taken.
    // Entered and left on a falling edge.
    task automatic send_word(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        byte_ch.in_last <= is_last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        @(negedge clk);
    endtask

    // Send frame_q as one data set; in_last marks its final byte.
    task automatic send_set();
        for (int i = 0; i < frame_q.size(); i++)
            send_word(frame_q[i], (i == frame_q.size() - 1));
        bytes_sent += frame_q.size();
        sets_sent++;
        frame_q.delete();
    endtask

    task automatic send_directed();
        // Zero size with an empty id: block ends on its terminator.
        put(8'hFF);
        put(8'h00);
        put(8'h00);
        put(8'h00);
        put(8'h00);
        send_set();
        // Six-byte header with the largest size, cut off in the payload.
        put(PFX_LONG6);
        put(8'h00);
        put(8'hFF);
        put(8'hFF);
        put(8'h00);
        put(8'h00);
        put(8'h00);
        put(8'h00);
        put(8'hFF);
        send_set();
        // Three-byte link container ending inside an inner header: overrun
        // reported on the data set's last byte.
        put(8'h00);
        put(8'h00);
        put(8'h03);
        put(8'(ID_NAME_LEN));
        for (int k = 0; k < ID_NAME_LEN; k++)
            put(LINKS_NAME[k]);
        put(8'h00);
        put(PFX_WIDE_B);
        put(8'h00);
        put(8'h05);
        send_set();
    endtask

    // One random data set. Mostly well-formed block sequences; the rest are
    // truncated sets, overrunning containers and raw noise.
    task automatic send_random_set();
        int r;
        int n_blocks;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            n_blocks = (r < 70) ? $urandom_range(1, 3) : $urandom_range(1, 2);
            repeat (n_blocks)
            begin
                if ($urandom_range(0, 99) < 45)
                    container_block(1'b0);
                else
                    plain_block(1'b0);
            end
            // cut the set short at a random byte
            if (r >= 70 && frame_q.size() > 1)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
        else if (r < 95)
        begin
            container_block(1'b1);
            if ($urandom_range(0, 1))
                plain_block(1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                put(rand_byte());
        end
        random_bytes += frame_q.size();
        send_set();
    endtask

    // Watchdog: ends the run when no word has moved on either channel for
    // the stretch that WATCHDOG_LIMIT sets.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (label_ch.valid && label_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        // every block input known from time zero
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = 8'h00;
        byte_ch.in_last = 1'b0;
        label_ch.ready  = 1'b0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_pace(PACE_FULL);
        send_directed();

        // Pacing rotates every 64 random bytes through all four modes.
        while (random_bytes < RANDOM_BYTES)
        begin
            set_pace(pace_t'((random_bytes / 64) % 4));
            send_random_set();
        end
        byte_ch.valid <= 1'b0;

        // drain: every label delivered, then a few spare cycles
        set_pace(PACE_FULL);
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Checked %0d labeled words: %0d inside containers, %0d overruns, %0d truncations",
                 words_checked, inner_words, overruns, truncations);
        $display("Sent %0d bytes (%0d random) in %0d data sets under four pacing modes",
                 bytes_sent, random_bytes, sets_sent);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/core/nbhd_pkg.sv
rtl/core/nbhd_if.sv
rtl/core/nbhd_step.sv
rtl/core/nested_block_header_deframer.sv
verif/nbhd_label_checker.sv
verif/testbench.sv
